// ===== hdl/symbolic_mode_parser_top_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the symbolic mode parser
// Shared property shapes for the checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef SYMBOLIC_MODE_PARSER_TOP_DEFINES_SVH
`define SYMBOLIC_MODE_PARSER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define SMP_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("symbolic mode parser check failed");

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define SMP_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("symbolic mode parser check failed");

`endif

// ===== hdl/smp_pkg.sv =====
// ----------------------------------------------------------------------------
// Symbolic mode parser package
// Types, mode bit constants, character codes and helper functions.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package smp_pkg;

  localparam int unsigned ModeW = 12;
  localparam int unsigned CharW = 8;

  // Mode bit groups.
  localparam logic [ModeW-1:0] M_USER   = 12'o5700;
  localparam logic [ModeW-1:0] M_GROUP  = 12'o2070;
  localparam logic [ModeW-1:0] M_OTHER  = 12'o0007;
  localparam logic [ModeW-1:0] M_ALL    = 12'o7777;
  localparam logic [ModeW-1:0] M_READ   = 12'o0444;
  localparam logic [ModeW-1:0] M_WRITE  = 12'o0222;
  localparam logic [ModeW-1:0] M_EXEC   = 12'o0111;
  localparam logic [ModeW-1:0] M_SETID  = 12'o6000;
  localparam logic [ModeW-1:0] M_STICKY = 12'o1000;
  localparam logic [ModeW-1:0] M_SGID   = 12'o2000;
  localparam logic [ModeW-1:0] M_GXEC   = 12'o0010;

  // Register reset values.
  localparam logic [ModeW-1:0] BASE_MODE_RST = 12'o0666;
  localparam logic [ModeW-1:0] UMASK_RST     = 12'o0022;

  // Configuration register indexes.
  localparam logic CFG_BASE_MODE = 1'b0;
  localparam logic CFG_UMASK     = 1'b1;

  // Character codes.
  localparam logic [CharW-1:0] CH_NUL   = 8'h00;
  localparam logic [CharW-1:0] CH_ZERO  = 8'h30;
  localparam logic [CharW-1:0] CH_SEVEN = 8'h37;
  localparam logic [CharW-1:0] CH_PLUS  = 8'h2b;
  localparam logic [CharW-1:0] CH_MINUS = 8'h2d;
  localparam logic [CharW-1:0] CH_EQ    = 8'h3d;
  localparam logic [CharW-1:0] CH_COMMA = 8'h2c;
  localparam logic [CharW-1:0] CH_U     = 8'h75;
  localparam logic [CharW-1:0] CH_G     = 8'h67;
  localparam logic [CharW-1:0] CH_O     = 8'h6f;
  localparam logic [CharW-1:0] CH_A     = 8'h61;
  localparam logic [CharW-1:0] CH_R     = 8'h72;
  localparam logic [CharW-1:0] CH_W     = 8'h77;
  localparam logic [CharW-1:0] CH_X     = 8'h78;
  localparam logic [CharW-1:0] CH_XUP   = 8'h58;
  localparam logic [CharW-1:0] CH_L     = 8'h6c;
  localparam logic [CharW-1:0] CH_S     = 8'h73;
  localparam logic [CharW-1:0] CH_T     = 8'h74;

  typedef enum logic [2:0] {
    PH_OCTAL,
    PH_WHO,
    PH_OP,
    PH_FIRST,
    PH_PERM
  } phase_e;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_ADD,
    OP_SUB,
    OP_SET
  } op_e;

  // One result item.
  typedef struct packed {
    logic [ModeW-1:0] mode;
    logic             invalid;
  } res_t;

  // Working mode and set-group-id flag after applying one operand.
  typedef struct packed {
    logic [ModeW-1:0] mode;
    logic             gid_touched;
  } apply_t;

  // Working mode at the start of a clause list: a locking base drops set-group-id.
  function automatic logic [ModeW-1:0] start_mode(input logic [ModeW-1:0] base);
    logic [ModeW-1:0] m;
    m = base;
    if ((m & (M_SGID | M_GXEC)) == M_SGID) begin
      m = m & ~M_SGID;
    end
    return m;
  endfunction

  // Apply one operand under the pending operator.
  function automatic apply_t apply_op(input logic [ModeW-1:0] b,
                                      input logic [ModeW-1:0] who,
                                      input logic [ModeW-1:0] hid,
                                      input op_e              op,
                                      input logic [ModeW-1:0] nm,
                                      input logic             gt);
    apply_t           r;
    logic [ModeW-1:0] sel;
    sel           = b & who & ~hid;
    r.mode        = nm;
    r.gid_touched = gt;
    case (op)
      OP_ADD: begin
        r.mode        = nm | sel;
        r.gid_touched = gt | (|(b & M_SGID));
      end
      OP_SUB: begin
        r.mode        = nm & ~sel;
        r.gid_touched = gt | (|(b & M_SGID));
      end
      OP_SET: begin
        r.mode = (nm & ~who) | sel;
      end
      default: begin
        r.mode = nm;
      end
    endcase
    return r;
  endfunction

  // Final mode: set-group-id follows the base unless an operand touched it.
  function automatic logic [ModeW-1:0] final_mode(input logic [ModeW-1:0] mode,
                                                  input logic [ModeW-1:0] base,
                                                  input logic             gt);
    logic [ModeW-1:0] m;
    m = mode;
    if (!gt) begin
      m = (mode & ~M_SGID) | (base & M_SGID);
    end
    return m;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/smp_in_stage.sv =====
// ----------------------------------------------------------------------------
// Symbolic mode parser input stage
// Holds one accepted character until the parser consumes it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module smp_in_stage
  import smp_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             s_axis_tvalid,
  output logic                  s_axis_tready,
  input  wire logic [CharW-1:0] s_axis_tdata,   // [7:0] char_in
  input  wire logic             advance_i,
  output logic                  valid_o,
  output logic [CharW-1:0]      char_o
);

  logic             valid_q, valid_d;
  logic [CharW-1:0] char_q;
  logic             fire;

  // A new transfer is taken when the register is empty or drains this cycle.
  assign s_axis_tready = !valid_q || advance_i;
  assign fire          = s_axis_tvalid && s_axis_tready;
  assign valid_d       = fire || (valid_q && !advance_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Character payload, loaded on each transfer.
  always_ff @(posedge clk_i) begin
    if (fire) begin
      char_q <= s_axis_tdata;
    end
  end

  assign valid_o = valid_q;
  assign char_o  = char_q;

endmodule

`default_nettype wire

// ===== hdl/smp_parser.sv =====
// ----------------------------------------------------------------------------
// Symbolic mode parser core
// Parser state and the combinational update for one character.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module smp_parser
  import smp_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             step_i,
  input  wire logic [CharW-1:0] char_i,
  input  wire logic [ModeW-1:0] base_mode_i,
  input  wire logic [ModeW-1:0] umask_i,
  output logic                  emit_o,
  output res_t                  res_o
);

  phase_e           phase_q, phase_d;
  op_e              op_q, op_d;
  logic [ModeW-1:0] mode_q, mode_d;
  logic [ModeW-1:0] oct_q, oct_d;
  logic [ModeW-1:0] who_q, who_d;
  logic [ModeW-1:0] hid_q, hid_d;
  logic [ModeW-1:0] perm_q, perm_d;
  logic             gt_q, gt_d;
  logic             err_q, err_d;

  // Next state for one character: a byte that closes a phase falls through to the later blocks.
  always_comb begin
    logic             done;
    logic             emit;
    logic [ModeW-1:0] emode;
    logic [2:0]       t;
    apply_t           ap;
    logic             is_copy;

    phase_d = phase_q;
    op_d    = op_q;
    mode_d  = mode_q;
    oct_d   = oct_q;
    who_d   = who_q;
    hid_d   = hid_q;
    perm_d  = perm_q;
    gt_d    = gt_q;
    err_d   = err_q;
    done    = 1'b0;
    emit    = 1'b0;
    emode   = mode_q;
    t       = 3'b000;
    ap      = '0;
    is_copy = (char_i == CH_U) || (char_i == CH_G) || (char_i == CH_O);

    if (err_q) begin
      // After a bad byte only the terminator matters.
      done = 1'b1;
      emit = (char_i == CH_NUL);
    end else begin
      // Leading octal digits.
      if (phase_d == PH_OCTAL) begin
        if (char_i >= CH_ZERO && char_i <= CH_SEVEN) begin
          oct_d = {oct_q[ModeW-4:0], char_i[2:0]};
          done  = 1'b1;
        end else if (char_i == CH_NUL) begin
          emode = oct_q;
          emit  = 1'b1;
          done  = 1'b1;
        end else begin
          mode_d  = start_mode(base_mode_i);
          who_d   = '0;
          hid_d   = '0;
          phase_d = PH_WHO;
        end
      end

      // Who letters.
      if (!done && phase_d == PH_WHO) begin
        if (char_i == CH_U) begin
          who_d = who_d | M_USER;
          done  = 1'b1;
        end else if (char_i == CH_G) begin
          who_d = who_d | M_GROUP;
          done  = 1'b1;
        end else if (char_i == CH_O) begin
          who_d = who_d | M_OTHER;
          done  = 1'b1;
        end else if (char_i == CH_A) begin
          who_d = who_d | M_ALL;
          done  = 1'b1;
        end else begin
          if (who_d == '0) begin
            who_d = M_ALL;
            hid_d = umask_i;
          end
          phase_d = PH_OP;
        end
      end

      // First character after an operator: a copy letter or the permission list.
      if (!done && phase_d == PH_FIRST) begin
        if (is_copy) begin
          if (char_i == CH_U) begin
            t = mode_d[8:6];
          end else if (char_i == CH_G) begin
            t = mode_d[5:3];
          end else begin
            t = mode_d[2:0];
          end
          ap      = apply_op({3'b000, t, t, t}, who_d, hid_d, op_d, mode_d, gt_d);
          mode_d  = ap.mode;
          gt_d    = ap.gid_touched;
          phase_d = PH_OP;
          done    = 1'b1;
        end else begin
          perm_d  = '0;
          phase_d = PH_PERM;
        end
      end

      // Permission letters; anything else closes the operand.
      if (!done && phase_d == PH_PERM) begin
        done = 1'b1;
        if (char_i == CH_R) begin
          perm_d = perm_d | M_READ;
        end else if (char_i == CH_W) begin
          perm_d = perm_d | M_WRITE;
        end else if (char_i == CH_X) begin
          perm_d = perm_d | M_EXEC;
        end else if (char_i == CH_XUP) begin
          if (|(base_mode_i & M_EXEC)) begin
            perm_d = perm_d | M_EXEC;
          end
        end else if (char_i == CH_L) begin
          perm_d = perm_d;
        end else if (char_i == CH_S) begin
          perm_d = perm_d | M_SETID;
        end else if (char_i == CH_T) begin
          perm_d = perm_d | M_STICKY;
        end else begin
          ap      = apply_op(perm_d, who_d, hid_d, op_d, mode_d, gt_d);
          mode_d  = ap.mode;
          gt_d    = ap.gid_touched;
          phase_d = PH_OP;
          done    = 1'b0;
        end
      end

      // Operator, clause separator or terminator.
      if (!done) begin
        if (char_i == CH_PLUS) begin
          op_d    = OP_ADD;
          phase_d = PH_FIRST;
        end else if (char_i == CH_MINUS) begin
          op_d    = OP_SUB;
          phase_d = PH_FIRST;
        end else if (char_i == CH_EQ) begin
          op_d    = OP_SET;
          phase_d = PH_FIRST;
        end else if (char_i == CH_COMMA) begin
          who_d   = '0;
          hid_d   = '0;
          op_d    = OP_NONE;
          phase_d = PH_WHO;
        end else if (char_i == CH_NUL) begin
          emode = mode_d;
          emit  = 1'b1;
        end else begin
          err_d = 1'b1;
        end
      end
    end

    // Result and restart for the next string.
    emit_o = emit && step_i;
    if (err_q) begin
      res_o.mode    = '0;
      res_o.invalid = 1'b1;
    end else begin
      res_o.mode    = final_mode(emode, base_mode_i, gt_d);
      res_o.invalid = 1'b0;
    end
    if (emit) begin
      phase_d = PH_OCTAL;
      op_d    = OP_NONE;
      mode_d  = start_mode(base_mode_i);
      oct_d   = '0;
      who_d   = '0;
      hid_d   = '0;
      perm_d  = '0;
      gt_d    = 1'b0;
      err_d   = 1'b0;
    end
  end

  // State registers, updated once per consumed character.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_OCTAL;
      op_q    <= OP_NONE;
      mode_q  <= start_mode(BASE_MODE_RST);
      oct_q   <= '0;
      who_q   <= '0;
      hid_q   <= '0;
      perm_q  <= '0;
      gt_q    <= 1'b0;
      err_q   <= 1'b0;
    end else if (step_i) begin
      phase_q <= phase_d;
      op_q    <= op_d;
      mode_q  <= mode_d;
      oct_q   <= oct_d;
      who_q   <= who_d;
      hid_q   <= hid_d;
      perm_q  <= perm_d;
      gt_q    <= gt_d;
      err_q   <= err_d;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/smp_out_stage.sv =====
// ----------------------------------------------------------------------------
// Symbolic mode parser output stage
// Result register on the master side of the stream.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module smp_out_stage
  import smp_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        load_i,
  input  wire res_t        res_i,
  output logic             free_o,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata,  // [11:0] mode_out, [15:12] zero
  output logic             m_axis_tuser   // [0] invalid
);

  logic valid_q, valid_d;
  res_t res_q;

  // The register can take a result when empty or when its transfer completes now.
  assign free_o  = !valid_q || m_axis_tready;
  assign valid_d = load_i || (valid_q && !m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata  = {4'b0000, res_q.mode};
  assign m_axis_tuser  = res_q.invalid;

endmodule

`default_nettype wire

// ===== hdl/symbolic_mode_parser_top.sv =====
// Symbolic mode parser: takes a chmod-style mode string one byte per transfer, ended by a
// zero byte, and returns one result per string (the 12-bit mode, or zero with the invalid
// flag set). One byte is taken every cycle as long as the result side keeps up; only a
// terminator can wait, and then only while the previous result is still unread. A result
// is registered: the parser update works on the terminator in the input register and
// loads the result register once that register is free.
// base_mode and umask are meant to be written between strings.
// ----------------------------------------------------------------------------
// Symbolic mode parser top level
// Input register, parser core, result register and configuration registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "symbolic_mode_parser_top_defines.svh"

module symbolic_mode_parser_top
  import smp_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  // Configuration write port.
  input  wire logic             cfg_we_i,
  input  wire logic             cfg_idx_i,
  input  wire logic [ModeW-1:0] cfg_wdata_i,
  // Character stream.
  input  wire logic             s_axis_tvalid,
  output logic                  s_axis_tready,
  input  wire logic [CharW-1:0] s_axis_tdata,   // [7:0] char_in
  // Result stream.
  output logic                  m_axis_tvalid,
  input  wire logic             m_axis_tready,
  output logic [15:0]           m_axis_tdata,   // [11:0] mode_out, [15:12] zero
  output logic                  m_axis_tuser    // [0] invalid
);

  logic [ModeW-1:0] base_mode_q;
  logic [ModeW-1:0] umask_q;
  logic             in_valid;
  logic [CharW-1:0] in_char;
  logic             advance;
  logic             out_free;
  logic             emit;
  res_t             res;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_mode_q <= BASE_MODE_RST;
      umask_q     <= UMASK_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_BASE_MODE: base_mode_q <= cfg_wdata_i;
        CFG_UMASK:     umask_q     <= cfg_wdata_i;
        default:       base_mode_q <= base_mode_q;
      endcase
    end
  end

  // Only a terminator produces a result, so only it waits for the result register.
  assign advance = in_valid && ((in_char != CH_NUL) || out_free);

  smp_in_stage u_in (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .advance_i     (advance),
    .valid_o       (in_valid),
    .char_o        (in_char)
  );

  smp_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (advance),
    .char_i      (in_char),
    .base_mode_i (base_mode_q),
    .umask_i     (umask_q),
    .emit_o      (emit),
    .res_o       (res)
  );

  smp_out_stage u_out (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (emit),
    .res_i         (res),
    .free_o        (out_free),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // A result is never loaded over one that is still waiting.
  `SMP_ASSERT_NOW(a_no_overwrite, emit, out_free)
  // A loaded result is presented in the next cycle.
  `SMP_ASSERT_NEXT(a_emit_shows, emit, m_axis_tvalid)
  // An invalid result always carries a zero mode.
  `SMP_ASSERT_NOW(a_invalid_zero, m_axis_tvalid && m_axis_tuser, m_axis_tdata == 16'h0000)
  // A transfer into a full input register implies that the held byte is consumed.
  `SMP_ASSERT_NOW(a_in_drain, s_axis_tvalid && s_axis_tready && in_valid, advance)

endmodule

`default_nettype wire

// ===== verif/symbolic_mode_parser_top_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Symbolic mode parser testbench
// Streams mode strings into the parser, one byte per transfer, and checks
// every result against a cycle-free model of the parser kept in this module
// or a typed table result. A short table of hand-picked strings runs first.
// Random strings follow in several phases, each under its own base mode and
// umask. Both stream sides idle in random bursts, except in phases 3 and 5.
// ----------------------------------------------------------------------------

module symbolic_mode_parser_top_test;
  import smp_pkg::*;

  localparam int CycleLimit  = 400000;
  localparam int RandomChars = 1830;
  localparam int RandPhases  = 6;
  localparam int DirRows     = 14;

  logic             clk_i         = 1'b0;
  logic             rst_ni        = 1'b0;
  logic             cfg_we_i      = 1'b0;
  logic             cfg_idx_i     = CFG_BASE_MODE;
  logic [ModeW-1:0] cfg_wdata_i   = '0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [CharW-1:0] s_axis_tdata  = '0;   // [7:0] char_in
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b1;
  logic [15:0]      m_axis_tdata;         // [11:0] mode_out, [15:12] zero
  logic             m_axis_tuser;         // [0] invalid

  symbolic_mode_parser_top DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // 4 ns clock.
  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  // Parser model state and its copy of the configuration.
  logic [ModeW-1:0] cfg_base  = BASE_MODE_RST;
  logic [ModeW-1:0] cfg_umask = UMASK_RST;
  phase_e           pm_phase  = PH_OCTAL;
  logic [ModeW-1:0] work_mode = BASE_MODE_RST;
  logic [ModeW-1:0] oct_acc   = '0;
  logic [ModeW-1:0] who_bits  = '0;
  logic [ModeW-1:0] hide_bits = '0;
  logic [ModeW-1:0] operand   = '0;
  op_e              pend_op   = OP_NONE;
  bit               sgid_hit  = 1'b0;
  bit               bad_seen  = 1'b0;

  res_t       expected_modes [$];
  logic [7:0] str_buf [$];
  int         mismatch_cnt = 0;
  int         chars_sent   = 0;
  int         cycle_cnt    = 0;
  int         stall_left   = 0;
  bit         idle_on      = 1'b1;

  logic [7:0] who_chars  [4] = '{CH_U, CH_G, CH_O, CH_A};
  logic [7:0] op_chars   [3] = '{CH_PLUS, CH_MINUS, CH_EQ};
  logic [7:0] perm_chars [7] = '{CH_R, CH_W, CH_X, CH_XUP, CH_L, CH_S, CH_T};

  // Directed strings; each row is sent followed by a zero byte.
  string      dir_text  [DirRows] = '{"", "17777", "ux", "\377", "u+rwxXlst", "g-x,o=u",
                                      "+w", "12a=r", "u=g,g+o", "7", "a-s", "=X",
                                      "o+X,g=", "u+r,"};
  logic [11:0] dir_base [DirRows] = '{12'o0666, 12'o0666, 12'o0666, 12'o0666, 12'o0666,
                                      12'o0666, 12'o0666, 12'o0666, 12'o0666, 12'o7777,
                                      12'o7777, 12'o2000, 12'o0000, 12'o0000};
  logic [11:0] dir_umask [DirRows] = '{12'o0022, 12'o0022, 12'o0022, 12'o0022, 12'o0022,
                                       12'o0022, 12'o0022, 12'o0022, 12'o0022, 12'o0000,
                                       12'o0000, 12'o7777, 12'o7777, 12'o0000};
  bit          dir_known [DirRows] = '{1, 1, 1, 1, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0};
  logic [11:0] dir_mode  [DirRows] = '{12'o0000, 12'o5777, 12'o0000, 12'o0000, 12'o0000,
                                       12'o0000, 12'o0000, 12'o0000, 12'o0000, 12'o2007,
                                       12'o0000, 12'o0000, 12'o0000, 12'o0000};
  bit          dir_bad   [DirRows] = '{0, 0, 1, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0};

  // Working mode at the start of the clauses: a locking base drops set-group-id.
  function automatic logic [ModeW-1:0] lock_base();
    logic [ModeW-1:0] m;
    m = cfg_base;
    if ((m & (M_SGID | M_GXEC)) == M_SGID) begin
      m = m & ~M_SGID;
    end
    return m;
  endfunction

  task automatic parser_restart();
    pm_phase  = PH_OCTAL;
    work_mode = lock_base();
    oct_acc   = '0;
    who_bits  = '0;
    hide_bits = '0;
    operand   = '0;
    pend_op   = OP_NONE;
    sgid_hit  = 1'b0;
    bad_seen  = 1'b0;
  endtask

  // Result of a finished string; set-group-id follows the base unless touched.
  task automatic emit_mode(output res_t r);
    if (bad_seen) begin
      r.mode    = '0;
      r.invalid = 1'b1;
    end else begin
      r.mode    = sgid_hit ? work_mode : ((work_mode & ~M_SGID) | (cfg_base & M_SGID));
      r.invalid = 1'b0;
    end
    parser_restart();
  endtask

  task automatic apply_operand(input logic [ModeW-1:0] b);
    logic [ModeW-1:0] sel;
    sel = b & who_bits & ~hide_bits;
    case (pend_op)
      OP_ADD: begin
        work_mode = work_mode | sel;
        if (|(b & M_SGID)) sgid_hit = 1'b1;
      end
      OP_SUB: begin
        work_mode = work_mode & ~sel;
        if (|(b & M_SGID)) sgid_hit = 1'b1;
      end
      OP_SET: begin
        work_mode = (work_mode & ~who_bits) | sel;
      end
      default: begin
      end
    endcase
  endtask

  // Advance the model by one byte; got is set when the byte ends a string.
  task automatic parse_mode_char(input logic [7:0] c, output bit got, output res_t r);
    bit         busy;
    logic [2:0] t;
    got  = 1'b0;
    r    = '0;
    busy = 1'b0;
    if (bad_seen) begin
      if (c == CH_NUL) begin
        emit_mode(r);
        got = 1'b1;
      end
    end else if (pm_phase == PH_OCTAL) begin
      if (c >= CH_ZERO && c <= CH_SEVEN) begin
        oct_acc = {oct_acc[8:0], c[2:0]};
      end else if (c == CH_NUL) begin
        work_mode = oct_acc;
        emit_mode(r);
        got = 1'b1;
      end else begin
        // Not a pure octal string: leading digits are dropped.
        work_mode = lock_base();
        who_bits  = '0;
        hide_bits = '0;
        pm_phase  = PH_WHO;
        busy      = 1'b1;
      end
    end else begin
      busy = 1'b1;
    end

    // A byte that closes one part of a clause is handed on to the next part.
    while (busy) begin
      busy = 1'b0;
      case (pm_phase)
        PH_WHO: begin
          if (c == CH_U) who_bits = who_bits | M_USER;
          else if (c == CH_G) who_bits = who_bits | M_GROUP;
          else if (c == CH_O) who_bits = who_bits | M_OTHER;
          else if (c == CH_A) who_bits = who_bits | M_ALL;
          else begin
            if (who_bits == '0) begin
              who_bits  = M_ALL;
              hide_bits = cfg_umask;
            end
            pm_phase = PH_OP;
            busy     = 1'b1;
          end
        end
        PH_FIRST: begin
          if (c == CH_U || c == CH_G || c == CH_O) begin
            t = (c == CH_U) ? work_mode[8:6] : (c == CH_G) ? work_mode[5:3] : work_mode[2:0];
            apply_operand({3'b000, t, t, t});
            pm_phase = PH_OP;
          end else begin
            operand  = '0;
            pm_phase = PH_PERM;
            busy     = 1'b1;
          end
        end
        PH_PERM: begin
          case (c)
            CH_R:   operand = operand | M_READ;
            CH_W:   operand = operand | M_WRITE;
            CH_X:   operand = operand | M_EXEC;
            CH_XUP: if (|(cfg_base & M_EXEC)) operand = operand | M_EXEC;
            CH_L:   ;
            CH_S:   operand = operand | M_SETID;
            CH_T:   operand = operand | M_STICKY;
            default: begin
              apply_operand(operand);
              pm_phase = PH_OP;
              busy     = 1'b1;
            end
          endcase
        end
        default: begin
          if (c == CH_PLUS || c == CH_MINUS || c == CH_EQ) begin
            pend_op  = (c == CH_PLUS) ? OP_ADD : (c == CH_MINUS) ? OP_SUB : OP_SET;
            pm_phase = PH_FIRST;
          end else if (c == CH_COMMA) begin
            who_bits  = '0;
            hide_bits = '0;
            pend_op   = OP_NONE;
            pm_phase  = PH_WHO;
          end else if (c == CH_NUL) begin
            emit_mode(r);
            got = 1'b1;
          end else begin
            bad_seen = 1'b1;
          end
        end
      endcase
    end
  endtask

  task automatic flag_mismatch(input string what, input logic [15:0] want,
                               input logic [15:0] seen);
    if (mismatch_cnt < 10) begin
      $display("Mismatch on %s: expected %o, got %o at %0t ns", what, want, seen, $time);
    end
    mismatch_cnt++;
  endtask

  // Send one byte; a typed result, where given, replaces the model's one.
  task automatic send_char(input logic [7:0] c, input bit typed, input res_t typed_res);
    bit   got;
    res_t pred;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= c;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    parse_mode_char(c, got, pred);
    if (got) expected_modes.push_back(typed ? typed_res : pred);
    chars_sent++;
  endtask

  // Let every result drain and the input register empty before a register write.
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (expected_modes.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_config(input logic [ModeW-1:0] base, input logic [ModeW-1:0] mask);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_BASE_MODE;
    cfg_wdata_i <= base;
    @(posedge clk_i);
    cfg_base    = base;
    cfg_idx_i   <= CFG_UMASK;
    cfg_wdata_i <= mask;
    @(posedge clk_i);
    cfg_umask   = mask;
    cfg_we_i    <= 1'b0;
  endtask

  // One random string: mostly well-formed clauses, some octal, some broken or noise.
  task automatic build_random_string();
    int kind;
    int nclause;
    int nops;
    int pos;
    kind = $urandom_range(0, 99);
    str_buf.delete();
    if (kind < 15) begin
      repeat ($urandom_range(0, 6)) str_buf.push_back(CH_ZERO + 8'($urandom_range(0, 7)));
    end else if (kind < 88) begin
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 3)) str_buf.push_back(CH_ZERO + 8'($urandom_range(0, 7)));
      end
      nclause = $urandom_range(1, 3);
      for (int k = 0; k < nclause; k++) begin
        if (k > 0) str_buf.push_back(CH_COMMA);
        repeat ($urandom_range(0, 3)) str_buf.push_back(who_chars[$urandom_range(0, 3)]);
        nops = $urandom_range(1, 3);
        repeat (nops) begin
          str_buf.push_back(op_chars[$urandom_range(0, 2)]);
          if ($urandom_range(0, 3) == 0) begin
            str_buf.push_back(who_chars[$urandom_range(0, 2)]);
          end else begin
            repeat ($urandom_range(0, 4)) str_buf.push_back(perm_chars[$urandom_range(0, 6)]);
          end
        end
      end
      // A stray byte somewhere in an otherwise good string.
      if (kind >= 78) begin
        pos = $urandom_range(0, str_buf.size());
        str_buf.insert(pos, 8'($urandom_range(1, 255)));
      end
    end else begin
      repeat ($urandom_range(1, 6)) str_buf.push_back(8'($urandom_range(1, 255)));
    end
    str_buf.push_back(CH_NUL);
  endtask

  // Result side: random stall bursts while idling is on.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (stall_left > 0) begin
        stall_left--;
        if (stall_left == 0) m_axis_tready <= 1'b1;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        m_axis_tready <= 1'b0;
        stall_left = $urandom_range(1, 15);
      end
    end
  end

  // Compare each result transfer with the oldest expected mode.
  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_modes.size() == 0) begin
        flag_mismatch("unexpected result", 16'h0000, m_axis_tdata);
      end else begin
        want = expected_modes.pop_front();
        if (m_axis_tdata !== {4'b0000, want.mode}) begin
          flag_mismatch("mode_out", {4'b0000, want.mode}, m_axis_tdata);
        end
        if (m_axis_tuser !== want.invalid) begin
          flag_mismatch("invalid", {15'd0, want.invalid}, {15'd0, m_axis_tuser});
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    res_t row_res;
    int   rand_start;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table; the configuration changes only between strings.
    for (int i = 0; i < DirRows; i++) begin
      if (dir_base[i] != cfg_base || dir_umask[i] != cfg_umask) begin
        wait_idle();
        set_config(dir_base[i], dir_umask[i]);
      end
      for (int k = 0; k < dir_text[i].len(); k++) begin
        send_char(dir_text[i].getc(k), 1'b0, '0);
      end
      row_res.mode    = dir_mode[i];
      row_res.invalid = dir_bad[i];
      send_char(CH_NUL, dir_known[i], row_res);
    end

    // Random phases, each under its own configuration; phases 3 and 5 run flat out.
    rand_start = chars_sent;
    for (int ph = 0; ph < RandPhases; ph++) begin
      wait_idle();
      case (ph)
        0: set_config(M_ALL, M_ALL);
        1: set_config('0, '0);
        3: set_config((12'($urandom_range(0, 4095)) | M_SGID) & ~M_GXEC,
                      12'($urandom_range(0, 4095)));
        default: set_config(12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)));
      endcase
      idle_on = (ph != 3) && (ph != RandPhases - 1);
      while (chars_sent - rand_start < (ph + 1) * RandomChars / RandPhases) begin
        build_random_string();
        foreach (str_buf[k]) send_char(str_buf[k], 1'b0, '0);
      end
    end

    s_axis_tvalid <= 1'b0;
    while (expected_modes.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (mismatch_cnt == 0 && expected_modes.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
